// ===== design/fba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and codes for the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  // request modes
  localparam logic [2:0] MODE_QUERY      = 3'd0;
  localparam logic [2:0] MODE_ALLOC      = 3'd1;
  localparam logic [2:0] MODE_FREE       = 3'd2;
  localparam logic [2:0] MODE_FIND       = 3'd3;
  localparam logic [2:0] MODE_FIND_ALLOC = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_NO_FRAME  = 2'd2;

  // byte addresses of the legacy hole
  localparam logic [31:0] HOLE_START = 32'h000A_0000;
  localparam logic [31:0] HOLE_END   = 32'h0010_0000;

  // sequencer states
  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXAM
  } fba_state_t;

endpackage

// ===== design/fba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module fba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/frame_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// Sequencing: one word at a time. It is accepted only while idle, which reads
//   its bitmap byte; the examine state finishes it, and a search reads one
//   further byte per step until it finds a clear bit or reaches the last byte.
//   A result word held back by the receiver stalls the sequencer until it
//   leaves. Reset: a clearing pass rewrites every bitmap byte with its
//   reserved-frame pattern; no word is accepted until it ends.
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// One bit per page frame (set = allocated): query, allocate, free and
// first-free search with optional allocate, sequenced over a byte-wide memory.
// PAGE_SIZE_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator
  import fba_pkg::*;
#(
  parameter int PAGE_SIZE_BYTES     = 4096,
  parameter int NUM_FRAMES          = 16384,
  parameter int RESERVED_LOW_FRAMES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // mode[2:0], address[34:3], zero[39:35]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // status[1:0], frame_address[33:2],
                                      // is_allocated[34], zero[39:35]
);

  localparam int BYTE_COUNT = (NUM_FRAMES + 7) / 8;
  localparam int BW         = $clog2(BYTE_COUNT);
  localparam int PAGE_SHIFT = $clog2(PAGE_SIZE_BYTES);
  localparam logic [BW-1:0] LAST_BYTE = BW'(BYTE_COUNT - 1);
  localparam logic [31:0] NUM_FRAMES_W = 32'(NUM_FRAMES);
  localparam logic [31:0] RES_LOW_W    = 32'(RESERVED_LOW_FRAMES);
  localparam logic [31:0] HOLE_FIRST   = HOLE_START >> PAGE_SHIFT;
  localparam logic [31:0] HOLE_LIMIT   = HOLE_END >> PAGE_SHIFT;

  // registers
  fba_state_t    state, state_next;
  logic [BW-1:0] ptr, ptr_next;
  logic [2:0]    mode_r, mode_r_next;
  logic [31:0]   addr_r, addr_r_next;
  logic          out_valid, out_valid_next;
  logic [39:0]   out_data, out_data_next;

  // memory port signals
  logic          ram_we;
  logic [BW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [BW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // request decode
  logic [2:0]  in_mode;
  logic [31:0] in_addr;
  logic [31:0] in_frame;
  logic [31:0] cur_frame;
  logic [2:0]  cur_bit;
  logic        out_free;

  // per-byte helpers
  logic [7:0]  init_byte;
  logic [7:0]  bit_valid;
  logic [7:0]  busy_bits;
  logic        hit_found;
  logic [2:0]  hit_idx;
  logic [31:0] bit_frame [8];

  assign in_mode   = s_axis_tdata[2:0];
  assign in_addr   = s_axis_tdata[34:3];
  assign in_frame  = in_addr >> PAGE_SHIFT;
  assign cur_frame = addr_r >> PAGE_SHIFT;
  assign cur_bit   = cur_frame[2:0];
  assign out_free  = !out_valid || m_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  fba_ram #(
    .WIDTH (8),
    .DEPTH (BYTE_COUNT)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // frame numbers of the eight bits of the current byte, reset pattern,
  // bits that lie inside the bitmap, and first clear bit
  always_comb begin
    init_byte = '0;
    bit_valid = '0;
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int b = 0; b < 8; b++) begin
      bit_frame[b] = 32'({ptr, 3'(b)});
      bit_valid[b] = bit_frame[b] < NUM_FRAMES_W;
      init_byte[b] = bit_valid[b] &&
                     ((bit_frame[b] < RES_LOW_W) ||
                      ((bit_frame[b] >= HOLE_FIRST) && (bit_frame[b] < HOLE_LIMIT)));
    end
    busy_bits = ram_rdata | ~bit_valid;
    for (int b = 7; b >= 0; b--) begin
      if (!busy_bits[b]) begin
        hit_found = 1'b1;
        hit_idx   = 3'(b);
      end
    end
  end

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ptr       <= ptr_next;
      out_valid <= out_valid_next;
    end
    mode_r   <= mode_r_next;
    addr_r   <= addr_r_next;
    out_data <= out_data_next;
  end

  // sequencer: clearing pass, accept, then byte-by-byte examination
  always_comb begin
    logic        finish;
    logic [1:0]  res_status;
    logic [31:0] res_addr;
    logic        res_alloc;
    logic        do_write;
    logic [7:0]  new_byte;
    logic        advance;

    finish     = 1'b0;
    res_status = STATUS_OK;
    res_addr   = addr_r;
    res_alloc  = 1'b0;
    do_write   = 1'b0;
    new_byte   = ram_rdata;
    advance    = 1'b0;

    state_next     = state;
    ptr_next       = ptr;
    mode_r_next    = mode_r;
    addr_r_next    = addr_r;
    out_valid_next = out_valid && !m_axis_tready;
    out_data_next  = out_data;
    ram_we         = 1'b0;
    ram_waddr      = ptr;
    ram_wdata      = init_byte;
    ram_raddr      = ptr;

    case (state)
      ST_INIT: begin
        ram_we = 1'b1;
        if (ptr == LAST_BYTE) begin
          state_next = ST_IDLE;
          ptr_next   = '0;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end

      ST_IDLE: begin
        ram_raddr = BW'(in_frame >> 3);
        if (s_axis_tvalid) begin
          mode_r_next = in_mode;
          addr_r_next = in_addr;
          ptr_next    = BW'(in_frame >> 3);
          state_next  = ST_EXAM;
        end
      end

      ST_EXAM: begin
        if (cur_frame >= NUM_FRAMES_W) begin
          finish     = 1'b1;
          res_status = STATUS_RANGE;
        end else begin
          case (mode_r)
            MODE_QUERY: begin
              finish    = 1'b1;
              res_alloc = ram_rdata[cur_bit];
            end
            MODE_ALLOC: begin
              finish   = 1'b1;
              do_write = 1'b1;
              new_byte = ram_rdata | (8'h01 << cur_bit);
            end
            MODE_FREE: begin
              finish   = 1'b1;
              do_write = 1'b1;
              new_byte = ram_rdata & ~(8'h01 << cur_bit);
            end
            MODE_FIND, MODE_FIND_ALLOC: begin
              if (hit_found) begin
                finish   = 1'b1;
                res_addr = 32'({ptr, hit_idx}) << PAGE_SHIFT;
                do_write = (mode_r == MODE_FIND_ALLOC);
                new_byte = ram_rdata | (8'h01 << hit_idx);
              end else if (ptr == LAST_BYTE) begin
                finish     = 1'b1;
                res_status = STATUS_NO_FRAME;
                res_addr   = '0;
              end else begin
                advance = 1'b1;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end

        if (advance) begin
          ptr_next  = ptr + 1'b1;
          ram_raddr = ptr + 1'b1;
        end else if (finish && out_free) begin
          ram_we         = do_write;
          ram_wdata      = new_byte;
          out_valid_next = 1'b1;
          out_data_next  = {5'd0, res_alloc, res_addr, res_status};
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== dv/frame_map_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_map_monitor
// Watches both stream channels of the frame bitmap allocator, keeps its own
// copy of the frame bitmap, predicts each result word and compares it field
// by field with the word the block returns.
// ----------------------------------------------------------------------------
module frame_map_monitor
  import fba_pkg::*;
#(
  parameter int PAGE_SIZE_BYTES     = 4096,
  parameter int NUM_FRAMES          = 16384,
  parameter int RESERVED_LOW_FRAMES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // mode[2:0], address[34:3], zero[39:35]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // status[1:0], frame_address[33:2],
                                      // is_allocated[34], zero[39:35]
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] frame_address;
    logic        is_allocated;
  } frame_reply_t;

  // one bit per frame, set = allocated
  logic [NUM_FRAMES-1:0] frame_used;
  frame_reply_t          replies_due[$];

  // clear the map, then mark the low kernel frames and the legacy hole
  function automatic void load_reserved_map();
    logic [31:0] a;
    frame_used = '0;
    for (int f = 0; f < RESERVED_LOW_FRAMES && f < NUM_FRAMES; f++) begin
      frame_used[f] = 1'b1;
    end
    for (a = HOLE_START; a < HOLE_END; a += PAGE_SIZE_BYTES) begin
      if (a / PAGE_SIZE_BYTES < NUM_FRAMES) begin
        frame_used[a / PAGE_SIZE_BYTES] = 1'b1;
      end
    end
  endfunction

  // apply one request to the map and return the reply it should produce
  function automatic frame_reply_t serve_request(logic [2:0] mode, logic [31:0] addr);
    frame_reply_t r;
    logic [31:0]  frame;
    int           f;
    int           hit;
    bit           found;
    r.status        = STATUS_OK;
    r.frame_address = addr;
    r.is_allocated  = 1'b0;
    frame = addr / PAGE_SIZE_BYTES;
    if (frame >= NUM_FRAMES) begin
      r.status = STATUS_RANGE;
    end else begin
      case (mode)
        MODE_QUERY: begin
          r.is_allocated = frame_used[frame];
        end
        MODE_ALLOC: begin
          frame_used[frame] = 1'b1;
        end
        MODE_FREE: begin
          frame_used[frame] = 1'b0;
        end
        MODE_FIND, MODE_FIND_ALLOC: begin
          // search starts at the first frame of the group of eight
          found = 1'b0;
          hit   = 0;
          for (f = int'(frame) & ~7; f < NUM_FRAMES && !found; f++) begin
            if (!frame_used[f]) begin
              found = 1'b1;
              hit   = f;
            end
          end
          if (found) begin
            r.frame_address = hit * PAGE_SIZE_BYTES;
            if (mode == MODE_FIND_ALLOC) begin
              frame_used[hit] = 1'b1;
            end
          end else begin
            r.status        = STATUS_NO_FRAME;
            r.frame_address = '0;
          end
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
    load_reserved_map();
  end

  always @(posedge clk) begin
    frame_reply_t want;
    frame_reply_t got;
    if (rst) begin
      load_reserved_map();
      replies_due.delete();
    end else begin
      // result word leaving the block
      if (m_axis_tvalid && m_axis_tready) begin
        got.status        = m_axis_tdata[1:0];
        got.frame_address = m_axis_tdata[33:2];
        got.is_allocated  = m_axis_tdata[34];
        if (replies_due.size() == 0) begin
          $error("result word with nothing expected: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.frame_address !== want.frame_address) begin
            $error("frame_address: expected %h, got %h",
                   want.frame_address, got.frame_address);
            mismatches++;
          end
          if (got.is_allocated !== want.is_allocated) begin
            $error("is_allocated: expected %0d, got %0d",
                   want.is_allocated, got.is_allocated);
            mismatches++;
          end
        end
      end
      // request word entering the block
      if (s_axis_tvalid && s_axis_tready) begin
        replies_due.push_back(serve_request(s_axis_tdata[2:0], s_axis_tdata[34:3]));
      end
    end
    outstanding = replies_due.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives query, allocate, free and first-free search requests into the frame
// bitmap allocator with bursty input and a stalling receiver; the monitor
// predicts and checks every result word.
// ----------------------------------------------------------------------------
module testbench;
  import fba_pkg::*;

  localparam int PAGE_SIZE_BYTES     = 4096;
  localparam int NUM_FRAMES          = 16384;
  localparam int RESERVED_LOW_FRAMES = 256;

  // modes the block leaves unused
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int RANDOM_REQUESTS = 900;
  localparam int WINDOW_FRAMES   = 2048;
  localparam int PRESSURE_AFTER  = 150;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;     // mode[2:0], address[34:3], zero[39:35]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;          // status[1:0], frame_address[33:2],
                                      // is_allocated[34], zero[39:35]

  int mismatches;
  int outstanding;
  int words_sent = 0;
  int burst_left = 0;

  frame_bitmap_allocator #(
    .PAGE_SIZE_BYTES    (PAGE_SIZE_BYTES),
    .NUM_FRAMES         (NUM_FRAMES),
    .RESERVED_LOW_FRAMES(RESERVED_LOW_FRAMES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  frame_map_monitor #(
    .PAGE_SIZE_BYTES    (PAGE_SIZE_BYTES),
    .NUM_FRAMES         (NUM_FRAMES),
    .RESERVED_LOW_FRAMES(RESERVED_LOW_FRAMES)
  ) monitor (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // byte address inside the given frame, random page offset
  function automatic logic [31:0] addr_in_frame(int frame);
    return frame * PAGE_SIZE_BYTES + $urandom_range(PAGE_SIZE_BYTES - 1, 0);
  endfunction

  // bursts of random length, random gaps between them
  task automatic send_request(input logic [2:0] mode, input logic [31:0] addr);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      if ($urandom_range(3, 0) != 0) begin
        gap = $urandom_range(12, 1);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 40'({$urandom(), $urandom()});
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, addr, mode};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
  endtask

  // receiver: runs of always-ready, random stalls and on-off stalls,
  // plus one long hold-off to back the block up
  initial begin : receiver
    int unsigned run_len;
    int unsigned kind;
    bit          held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (!held && words_sent >= PRESSURE_AFTER) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        kind    = $urandom_range(2, 0);
        run_len = $urandom_range(60, 4);
        for (int i = 0; i < run_len; i++) begin
          case (kind)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(99, 0) < 60);
            default: m_axis_tready <= i[1];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int unsigned pick;
    int unsigned count;
    int          base;
    int          frame;
    logic [2:0]  mode;
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reserved frames, range edges, repeat allocate and free
    send_request(MODE_QUERY, 32'h0000_0000);
    send_request(MODE_QUERY, HOLE_START);
    send_request(MODE_QUERY, 32'h0010_0FFF);
    send_request(MODE_QUERY, 32'hFFFF_FFFF);
    send_request(MODE_ALLOC, NUM_FRAMES * PAGE_SIZE_BYTES);
    send_request(MODE_FREE, NUM_FRAMES * PAGE_SIZE_BYTES - 1);
    send_request(MODE_ALLOC, 32'h0010_0000);
    send_request(MODE_ALLOC, 32'h0010_0000);
    send_request(MODE_QUERY, 32'h0010_0000);
    // search from the bottom, and from high in a group (returns a lower frame)
    send_request(MODE_FIND, 32'h0000_0000);
    send_request(MODE_FIND_ALLOC, 32'h0010_7FFF);
    send_request(MODE_FREE, 32'h0010_0000);
    send_request(MODE_FREE, 32'h0010_0000);
    send_request(MODE_FIND, 32'h0000_0123);
    // fill the top group, then search finds nothing
    for (int f = NUM_FRAMES - 8; f < NUM_FRAMES; f++) begin
      send_request(MODE_ALLOC, f * PAGE_SIZE_BYTES);
    end
    send_request(MODE_FIND, (NUM_FRAMES - 8) * PAGE_SIZE_BYTES);
    send_request(MODE_FIND_ALLOC, NUM_FRAMES * PAGE_SIZE_BYTES - 1);
    // unused modes
    send_request(MODE_SPARE_LO, 32'h0010_0000);
    send_request(MODE_SPARE_LO + 3'd1, 32'h0000_0000);
    send_request(MODE_SPARE_HI, 32'hFFFF_FFFF);

    count = words_sent + RANDOM_REQUESTS;
    while (words_sent < count) begin
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
        // single request, mostly in the low window
        mode = 3'($urandom_range(MODE_FIND_ALLOC, MODE_QUERY));
        case ($urandom_range(19, 0))
          0, 1, 2:    frame = $urandom_range(NUM_FRAMES - 1, NUM_FRAMES - 16);
          3, 4, 5, 6,
          7:          frame = $urandom_range(NUM_FRAMES - 1, 0);
          default:    frame = $urandom_range(WINDOW_FRAMES - 1, 0);
        endcase
        send_request(mode, addr_in_frame(frame));
      end else if (pick < 85) begin
        // run of allocating searches from one base, then frees and queries
        base = $urandom_range(WINDOW_FRAMES - 1, 0);
        if ($urandom_range(3, 0) == 0) begin
          base = $urandom_range(NUM_FRAMES - 1, NUM_FRAMES - 24);
        end
        pick = $urandom_range(12, 3);
        for (int i = 0; i < pick; i++) begin
          send_request(MODE_FIND_ALLOC, addr_in_frame(base));
        end
        for (int i = 0; i < pick; i++) begin
          frame = (base & ~7) + $urandom_range(pick - 1, 0);
          if (frame >= NUM_FRAMES) begin
            frame = NUM_FRAMES - 1;
          end
          if ($urandom_range(2, 0) == 0) begin
            send_request(MODE_QUERY, addr_in_frame(frame));
          end else begin
            send_request(MODE_FREE, addr_in_frame(frame));
          end
        end
      end else begin
        // noise: any mode, any address
        send_request(3'($urandom_range(MODE_SPARE_HI, MODE_QUERY)), $urandom());
      end
    end
    s_axis_tvalid <= 1'b0;

    // let the monitor register the last word before waiting on it
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog: covers the clearing pass and every request walking the whole
  // bitmap under the longest stalls, several times over
  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
